// ===== rtl/srsg_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the ramp step generator
package srsg_pkg;

   localparam int AXES_DEF     = 3;
   localparam int POS_BITS_DEF = 32;
   localparam int NUM_W        = 24;
   localparam int DEN_W        = 16;
   localparam int CNT_W        = 5;

   localparam logic [7:0]  MIN_SPEED_RST = 8'd30;
   localparam logic [7:0]  PEAK_RST      = 8'd140;
   localparam logic [15:0] FULL_RAMP_RST = 16'd1024;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_SET,
      KIND_ZERO,
      KIND_SETTLE
   } kind_type;

   typedef enum logic [1:0] {
      CSR_RELATIVE,
      CSR_ENDSTOP,
      CSR_MIN_SPEED,
      CSR_FULL_RAMP
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_WRITE,
      ST_FIN_READ,
      ST_FIN_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEG_DOWN,
      SEG_UP,
      SEG_CRUISE
   } seg_type;

   typedef struct packed {
      kind_type           kind;
      logic [1:0]         axis;
      logic signed [31:0] target_steps;
      logic [7:0]         peak_speed;
      logic [2:0]         limit_mask;
      logic               hold;
   } req_type;

   typedef struct packed {
      logic [2:0]         half_step_mask;
      logic [2:0]         direction_mask;
      logic [2:0]         moving_mask;
      logic               accepted;
      logic signed [31:0] axis_position;
   } rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ===== rtl/srsg_div.sv =====
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module srsg_div
   import srsg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quo
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_in;
   logic             bit_in;

   always_comb begin
      rem_sh = {rem_ff[DEN_W-1:0], quo_ff[NUM_W-1]};
      if (rem_sh >= {1'b0, den_ff}) begin
         rem_in = rem_sh - {1'b0, den_ff};
         bit_in = 1'b1;
      end else begin
         rem_in = rem_sh;
         bit_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], bit_in};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== rtl/srsg_mem.sv =====
`timescale 1ns / 1ps
// per-axis state memory with registered read and entry valid bits
module srsg_mem
   import srsg_pkg::*;
#(
   parameter int DEPTH = AXES_DEF,
   parameter int AW    = 2,
   parameter int EW    = 3 * POS_BITS_DEF + 24
)(
   input  logic          clock,
   input  logic          reset,
   input  mem_ctl_type   ctl,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   output logic [EW-1:0] rd_data
);

   logic [EW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [EW-1:0]    rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/stepper_ramp_step_generator.sv =====
`timescale 1ns / 1ps
// Three-axis half-step generator with acceleration ramp, top level.
// req channel: one item per transfer (tick, set target, zero axis, settle here).
// rsp channel: exactly one result per item, in order.
// csr port: plain write of relative mode, endstop, min speed and full ramp length.
// Items are handled one at a time. Per-axis state lives in a small memory with
// a registered read; set target and settle read, modify and write back one entry,
// zero axis writes its entry without reading it, and an out-of-range axis or a
// held set target writes nothing. A tick visits every axis in turn and writes back
// each axis that moves, which uses the serial divider that all axes share; a tick
// blocked by hold or endstop visits no axis and goes straight to its result.
// The result sits in an output register; a new item is taken while it waits.
// When the receiver stalls, the result holds and the block stalls before its
// next result. Reset clears all axis state, registers go to their defaults,
// and items are taken right away.
module stepper_ramp_step_generator
   import srsg_pkg::*;
#(
   parameter int AXES          = AXES_DEF,
   parameter int POSITION_BITS = POS_BITS_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data
);

   localparam int P  = POSITION_BITS;
   localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int EW = 3 * P + 24;

   state_type       state_ff, state_in;
   req_type         req_ff;
   logic            blk_ff;
   logic [AW-1:0]   cur_ff;
   logic [AXES-1:0] dir_ff;
   logic [AXES-1:0] moving_ff;
   logic [AXES-1:0] steps_ff;
   logic [7:0]      peak_ff;
   logic            rel_ff;
   logic            endstop_ff;
   logic [7:0]      min_ff;
   logic [15:0]     full_ff;

   logic [P-1:0]    ent_pos_ff, ent_src_ff, ent_tgt_ff;
   logic [15:0]     ent_ramp_ff;
   logic [7:0]      ent_acc_ff;
   logic            up_ff;
   logic            neg_ff;
   logic [7:0]      base_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;

   rsp_type         rsp_ff;
   logic            rsp_valid_ff;

   mem_ctl_type     mctl;
   logic [AW-1:0]   rd_addr;
   logic [EW-1:0]   wr_data;
   logic [EW-1:0]   rd_data;
   logic [P-1:0]    r_pos, r_src, r_tgt;
   logic [15:0]     r_ramp;
   logic [7:0]      r_acc;

   logic            div_start;
   logic            div_done;
   logic [NUM_W-1:0] div_quo;

   logic            accept;
   logic            axis_ok;
   logic            last_axis;

   // tick datapath
   logic signed [P:0] diff, from_d;
   logic [P:0]        dist_m, from_m;
   logic signed [8:0] span;
   logic [8:0]        span_abs;
   seg_type           seg;
   logic [7:0]        mul_a;
   logic [15:0]       mul_b;
   logic [15:0]       full_nz;
   logic signed [25:0] sq, sp;
   logic [7:0]        speed;
   logic [8:0]        acc9;

   // set target datapath
   logic signed [63:0] tsext;
   logic [P-1:0]       t0, tnew;
   logic signed [P:0]  tdiff;
   logic [P:0]         tabs, thalf;
   logic [15:0]        tramp;
   logic               tdir;

   logic signed [63:0] pos_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign axis_ok   = (int'(req_ff.axis) < AXES);
   assign last_axis = (cur_ff == AW'(AXES - 1));

   assign {r_pos, r_src, r_tgt, r_ramp, r_acc} = rd_data;
   assign wr_data = {ent_pos_ff, ent_src_ff, ent_tgt_ff, ent_ramp_ff, ent_acc_ff};

   srsg_mem #(.DEPTH(AXES), .AW(AW), .EW(EW)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mctl),
      .rd_addr (rd_addr),
      .wr_addr (cur_ff),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   srsg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      diff     = $signed({r_tgt[P-1], r_tgt}) - $signed({r_pos[P-1], r_pos});
      dist_m   = diff[P] ? (P+1)'(-diff) : diff;
      from_d   = $signed({r_pos[P-1], r_pos}) - $signed({r_src[P-1], r_src});
      from_m   = from_d[P] ? (P+1)'(-from_d) : from_d;
      span     = $signed({1'b0, peak_ff}) - $signed({1'b0, min_ff});
      span_abs = span[8] ? 9'(-span) : span;
      full_nz  = (full_ff == 16'd0) ? 16'd1 : full_ff;
      if (dist_m < (P+1)'(r_ramp)) begin
         seg = SEG_DOWN;
      end else if (from_m < (P+1)'(r_ramp)) begin
         seg = SEG_UP;
      end else begin
         seg = SEG_CRUISE;
      end
      case (seg)
         SEG_DOWN: begin
            mul_a = span_abs[7:0];
            mul_b = dist_m[15:0];
         end
         SEG_UP: begin
            mul_a = span_abs[7:0];
            mul_b = from_m[15:0];
         end
         default: begin
            mul_a = peak_ff;
            mul_b = r_ramp;
         end
      endcase

      sq    = neg_ff ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
      sp    = $signed({18'd0, base_ff}) + sq;
      if (sp < 0) begin
         speed = 8'd0;
      end else if (sp > 26'sd255) begin
         speed = 8'd255;
      end else begin
         speed = sp[7:0];
      end
      acc9 = {1'b0, ent_acc_ff} + {1'b0, speed};

      tsext = 64'(req_ff.target_steps);
      t0    = tsext[P-1:0];
      tnew  = rel_ff ? (t0 + r_pos) : t0;
      tdir  = $signed(tnew) > $signed(r_pos);
      tdiff = $signed({tnew[P-1], tnew}) - $signed({r_pos[P-1], r_pos});
      tabs  = tdiff[P] ? (P+1)'(-tdiff) : tdiff;
      thalf = tabs >> 1;
      tramp = (thalf < (P+1)'(full_ff)) ? thalf[15:0] : full_ff;

      pos_ext = 64'($signed(r_pos));
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      mctl.rd_en  = 1'b0;
      mctl.wr_en  = 1'b0;
      rd_addr     = cur_ff;
      div_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req.kind == KIND_TICK) begin
                  if (req.hold || (endstop_ff && (req.limit_mask != 3'd0))) begin
                     state_in = ST_FIN_READ;
                  end else begin
                     state_in = ST_READ;
                  end
               end else if (int'(req.axis) >= AXES) begin
                  state_in = ST_FIN_READ;
               end else if (req.kind == KIND_SET && req.hold) begin
                  state_in = ST_FIN_READ;
               end else if (req.kind == KIND_ZERO) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            mctl.rd_en = 1'b1;
            state_in   = ST_CALC;
         end
         ST_CALC: begin
            if (req_ff.kind == KIND_TICK) begin
               if (diff == '0) begin
                  state_in = last_axis ? ST_FIN_READ : ST_READ;
               end else begin
                  state_in = ST_DIV_GO;
               end
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            mctl.wr_en = 1'b1;
            if (req_ff.kind == KIND_TICK && !last_axis) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FIN_READ;
            end
         end
         ST_FIN_READ: begin
            mctl.rd_en = axis_ok;
            rd_addr    = AW'(req_ff.axis);
            state_in   = ST_FIN_OUT;
         end
         ST_FIN_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         rel_ff     <= 1'b0;
         endstop_ff <= 1'b1;
         min_ff     <= MIN_SPEED_RST;
         full_ff    <= FULL_RAMP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RELATIVE:  rel_ff     <= csr_wr_data[0];
            CSR_ENDSTOP:   endstop_ff <= csr_wr_data[0];
            CSR_MIN_SPEED: min_ff     <= csr_wr_data[7:0];
            CSR_FULL_RAMP: full_ff    <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= '0;
         moving_ff    <= '0;
         peak_ff      <= PEAK_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_CALC && req_ff.kind == KIND_SET) begin
            dir_ff[cur_ff] <= tdir;
            peak_ff        <= req_ff.peak_speed;
         end
         if (state_ff == ST_WRITE) begin
            moving_ff[cur_ff] <= (ent_tgt_ff != ent_pos_ff);
         end
         if (state_ff == ST_FIN_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_ff      <= req;
               blk_ff      <= endstop_ff && (req.limit_mask != 3'd0);
               steps_ff    <= '0;
               cur_ff      <= (req.kind == KIND_TICK) ? '0 : AW'(req.axis);
               ent_pos_ff  <= '0;
               ent_src_ff  <= '0;
               ent_tgt_ff  <= '0;
               ent_ramp_ff <= '0;
               ent_acc_ff  <= '0;
            end
         end
         ST_CALC: begin
            ent_pos_ff  <= r_pos;
            ent_src_ff  <= r_src;
            ent_tgt_ff  <= r_tgt;
            ent_ramp_ff <= r_ramp;
            ent_acc_ff  <= r_acc;
            up_ff       <= !diff[P];
            num_ff      <= NUM_W'(mul_a * mul_b);
            den_ff      <= (seg == SEG_DOWN) ? r_ramp : full_nz;
            neg_ff      <= (seg != SEG_CRUISE) && span[8];
            base_ff     <= (seg == SEG_CRUISE) ? 8'd0 : min_ff;
            case (req_ff.kind)
               KIND_TICK: begin
                  if (diff == '0 && !last_axis) begin
                     cur_ff <= cur_ff + 1'b1;
                  end
               end
               KIND_SET: begin
                  ent_src_ff  <= r_pos;
                  ent_tgt_ff  <= tnew;
                  ent_ramp_ff <= tramp;
               end
               KIND_SETTLE: begin
                  ent_tgt_ff <= r_pos;
               end
               default: begin
               end
            endcase
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               ent_acc_ff <= acc9[7:0];
               if (acc9[8]) begin
                  steps_ff[cur_ff] <= 1'b1;
                  ent_pos_ff <= up_ff ? (ent_pos_ff + 1'b1) : (ent_pos_ff - 1'b1);
               end
            end
         end
         ST_WRITE: begin
            if (req_ff.kind == KIND_TICK && !last_axis) begin
               cur_ff <= cur_ff + 1'b1;
            end
         end
         ST_FIN_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int i = 0; i < 3; i++) begin
                  rsp_ff.half_step_mask[i] <= (i < AXES) ? steps_ff[i] : 1'b0;
                  rsp_ff.direction_mask[i] <= (i < AXES) ? dir_ff[i] : 1'b0;
                  rsp_ff.moving_mask[i]    <= (i < AXES) ? (moving_ff[i] && !blk_ff) : 1'b0;
               end
               rsp_ff.accepted      <= !(req_ff.kind == KIND_SET && req_ff.hold);
               rsp_ff.axis_position <= axis_ok ? pos_ext[31:0] : 32'sd0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== rtl/srsg_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the ramp step generator and their binding
module srsg_props
   import srsg_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item taken while one is at work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
      else $error("stalled result changed");

endmodule

bind stepper_ramp_step_generator srsg_props u_srsg_props (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

// ===== verif/srsg_checker.sv =====
`timescale 1ns / 1ps
// checker for the ramp step generator: predicts each result and compares it
module srsg_checker
   import srsg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wr_data,
   output int          fail_count,
   output int          pending
);

   logic signed [31:0] pos [3];
   logic signed [31:0] src [3];
   logic signed [31:0] tgt [3];
   logic [15:0]        ramp [3];
   logic [7:0]         accum [3];
   logic [2:0]         dir_bits;
   logic [7:0]         peak;
   logic               rel_mode;
   logic               endstop_on;
   logic [7:0]         min_spd;
   logic [15:0]        full_ramp;
   rsp_type            expected_q [$];

   assign pending = expected_q.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   task automatic advance_axes(output logic [2:0] steps);
      longint full, span, diff, dst, rl, from, speed, acc;
      steps = '0;
      full = (full_ramp == 0) ? 1 : full_ramp;
      span = longint'(peak) - longint'(min_spd);
      for (int a = 0; a < 3; a++) begin
         diff = longint'(tgt[a]) - longint'(pos[a]);
         if (diff != 0) begin
            dst = diff < 0 ? -diff : diff;
            rl = ramp[a];
            from = longint'(pos[a]) - longint'(src[a]);
            if (from < 0) from = -from;
            if (dst < rl) speed = longint'(min_spd) + (span * dst) / rl;
            else if (from < rl) speed = longint'(min_spd) + (span * from) / full;
            else speed = (longint'(peak) * rl) / full;
            if (speed < 0) speed = 0;
            if (speed > 255) speed = 255;
            acc = longint'(accum[a]) + speed;
            if (acc >= 256) begin
               acc -= 256;
               pos[a] = diff > 0 ? pos[a] + 1 : pos[a] - 1;
               steps[a] = 1'b1;
            end
            accum[a] = acc[7:0];
         end
      end
   endtask

   task automatic predict(input req_type r);
      rsp_type e;
      logic blocked, ok;
      logic signed [31:0] t;
      longint half;
      int ax;
      e = '0;
      e.accepted = 1'b1;
      ax = r.axis;
      blocked = endstop_on && r.limit_mask != 0;
      ok = ax < 3;
      case (r.kind)
         KIND_TICK: begin
            if (!r.hold && !blocked) advance_axes(e.half_step_mask);
         end
         KIND_SET: begin
            if (r.hold) begin
               e.accepted = 1'b0;
            end else if (ok) begin
               t = r.target_steps;
               peak = r.peak_speed;
               if (rel_mode) t = t + pos[ax];
               dir_bits[ax] = t > pos[ax];
               src[ax] = pos[ax];
               tgt[ax] = t;
               half = (longint'(t) - longint'(src[ax])) / 2;
               if (half < 0) half = -half;
               ramp[ax] = (longint'(full_ramp) > half) ? half[15:0] : full_ramp;
            end
         end
         KIND_ZERO: begin
            if (ok) begin
               pos[ax] = 0; src[ax] = 0; tgt[ax] = 0; ramp[ax] = 0; accum[ax] = 0;
            end
         end
         default: begin
            if (ok) tgt[ax] = pos[ax];
         end
      endcase
      e.direction_mask = dir_bits;
      for (int a = 0; a < 3; a++)
         e.moving_mask[a] = !blocked && tgt[a] != pos[a];
      e.axis_position = ok ? pos[ax] : 32'sd0;
      expected_q.push_back(e);
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            pos[a] = 0; src[a] = 0; tgt[a] = 0; ramp[a] = 0; accum[a] = 0;
         end
         dir_bits = '0;
         peak = PEAK_RST;
         rel_mode = 1'b0;
         endstop_on = 1'b1;
         min_spd = MIN_SPEED_RST;
         full_ramp = FULL_RAMP_RST;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_RELATIVE:  rel_mode = csr_wr_data[0];
               CSR_ENDSTOP:   endstop_on = csr_wr_data[0];
               CSR_MIN_SPEED: min_spd = csr_wr_data[7:0];
               CSR_FULL_RAMP: full_ramp = csr_wr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict(req);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               report("unexpected transfer", 1, 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp.half_step_mask != e.half_step_mask)
                  report("half_step_mask", rsp.half_step_mask, e.half_step_mask);
               if (rsp.direction_mask != e.direction_mask)
                  report("direction_mask", rsp.direction_mask, e.direction_mask);
               if (rsp.moving_mask != e.moving_mask)
                  report("moving_mask", rsp.moving_mask, e.moving_mask);
               if (rsp.accepted != e.accepted)
                  report("accepted", rsp.accepted, e.accepted);
               if (rsp.axis_position != e.axis_position)
                  report("axis_position", rsp.axis_position, e.axis_position);
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ===== verif/tb_stepper_ramp_step_generator.sv =====
`timescale 1ns / 1ps
// testbench top for the ramp step generator: stimulus, clock, reset and verdict
module tb_stepper_ramp_step_generator;
   import srsg_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wr_data = '0;
   int          fail_count;
   int          pending;
   logic        calm = 1'b0;

   stepper_ramp_step_generator dut (.*);

   srsg_checker checker_i (.*);

   always #10 clock = ~clock;

   initial begin
      #200ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver stalls at random except during the calm stretch
   always @(negedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 9);

   // valid stays high after a transfer unless the next call idles first
   task automatic send(input req_type r);
      while (!calm && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic req_type make(input kind_type k, input int ax,
                                    input logic [31:0] t, input logic [7:0] pk,
                                    input logic [2:0] lim, input logic hd);
      req_type r;
      r.kind = k;
      r.axis = 2'(ax);
      r.target_steps = t;
      r.peak_speed = pk;
      r.limit_mask = lim;
      r.hold = hd;
      return r;
   endfunction

   function automatic req_type random_item();
      int sel;
      logic [31:0] t;
      sel = $urandom_range(99);
      case ($urandom_range(3))
         0: t = $urandom;
         1: t = $urandom_range(20) - 10;
         default: t = $urandom_range(120) - 60;
      endcase
      if (sel < 70)
         return make(KIND_TICK, $urandom_range(3), $urandom, 8'($urandom),
                     3'(($urandom_range(9) == 0) ? $urandom_range(7, 1) : 0),
                     $urandom_range(19) == 0);
      if (sel < 88)
         return make(KIND_SET, $urandom_range(3), t, 8'($urandom),
                     3'($urandom), $urandom_range(9) == 0);
      if (sel < 93)
         return make(KIND_ZERO, $urandom_range(3), $urandom, 8'($urandom),
                     3'($urandom), 1'($urandom));
      return make(KIND_SETTLE, $urandom_range(3), $urandom, 8'($urandom),
                  3'($urandom), 1'($urandom));
   endfunction

   initial begin
      repeat (12) @(negedge clock);
      reset = 1'b0;
      // directed part
      send(make(KIND_SET, 0, 32'sd40, 8'd255, 3'd0, 1'b0));
      send(make(KIND_SET, 1, -32'sd1, 8'd0, 3'd0, 1'b0));
      send(make(KIND_SET, 2, 32'sh7fffffff, 8'd200, 3'd0, 1'b1));
      send(make(KIND_SET, 3, 32'sd5, 8'd9, 3'd0, 1'b0));
      repeat (6) send(make(KIND_TICK, 0, 32'd0, 8'd0, 3'd0, 1'b0));
      send(make(KIND_TICK, 0, 32'd0, 8'd0, 3'd7, 1'b0));
      send(make(KIND_TICK, 0, 32'd0, 8'd0, 3'd0, 1'b1));
      send(make(KIND_SETTLE, 0, 32'd0, 8'd0, 3'd0, 1'b1));
      send(make(KIND_ZERO, 1, 32'd0, 8'd0, 3'd0, 1'b1));
      send(make(KIND_ZERO, 3, 32'd0, 8'd0, 3'd0, 1'b0));
      send(make(KIND_SETTLE, 3, 32'd0, 8'd0, 3'd0, 1'b0));
      send(make(KIND_SET, 2, 32'sh80000000, 8'd255, 3'd0, 1'b0));
      send(make(KIND_TICK, 2, 32'd0, 8'd0, 3'd0, 1'b0));
      send(make(KIND_ZERO, 2, 32'd0, 8'd0, 3'd0, 1'b0));
      // random phases under several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            1: begin
               write_reg(CSR_RELATIVE, 16'd1);
               write_reg(CSR_MIN_SPEED, 16'd255);
               write_reg(CSR_FULL_RAMP, 16'd0);
            end
            2: begin
               write_reg(CSR_ENDSTOP, 16'd0);
               write_reg(CSR_FULL_RAMP, 16'hffff);
               write_reg(CSR_MIN_SPEED, 16'd0);
            end
            3: begin
               write_reg(CSR_RELATIVE, 16'd0);
               write_reg(CSR_FULL_RAMP, 16'd4);
               write_reg(CSR_MIN_SPEED, 16'd120);
            end
            4: calm = 1'b1;
            5: begin
               calm = 1'b0;
               write_reg(CSR_ENDSTOP, 16'd1);
               write_reg(CSR_FULL_RAMP, 16'd1);
               write_reg(CSR_MIN_SPEED, 16'd200);
            end
            6: begin
               write_reg(CSR_RELATIVE, 16'd1);
               write_reg(CSR_MIN_SPEED, 16'd30);
               write_reg(CSR_FULL_RAMP, 16'd16);
            end
            7: write_reg(CSR_ENDSTOP, 16'hfffe);
            default: ;
         endcase
         repeat (200) send(random_item());
      end
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/srsg_pkg.sv
rtl/srsg_div.sv
rtl/srsg_mem.sv
rtl/stepper_ramp_step_generator.sv
rtl/srsg_checker.sv
verif/srsg_checker.sv
verif/tb_stepper_ramp_step_generator.sv
